/* rtl/core/tlvx_pkg.sv */
package tlvx_pkg;

    localparam logic [2:0] PH_TAG      = 3'd0;
    localparam logic [2:0] PH_SKIPLEN  = 3'd1;
    localparam logic [2:0] PH_SKIP     = 3'd2;
    localparam logic [2:0] PH_MATCHLEN = 3'd3;
    localparam logic [2:0] PH_VALUE    = 3'd4;
    localparam logic [2:0] PH_DONE     = 3'd5;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_BADLEN   = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    localparam logic [7:0] LEN_ONE  = 8'd1;
    localparam logic [7:0] LEN_TWO  = 8'd2;
    localparam logic [7:0] LEN_FOUR = 8'd4;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  skip_count;
        logic [31:0] value_accum;
        logic [2:0]  value_len;
        logic [1:0]  byte_index;
    } parse_state_t;

    typedef struct packed {
        logic        emit;
        logic [1:0]  status;
        logic [31:0] value;
    } parse_result_t;

    localparam parse_state_t STATE_REARM = '{
        phase:       PH_TAG,
        skip_count:  8'd0,
        value_accum: 32'd0,
        value_len:   3'd0,
        byte_index:  2'd0
    };

endpackage

/* rtl/core/tlvx_step.sv */
module tlvx_step (
    input  tlvx_pkg::parse_state_t  cur,
    input  logic [7:0]              target_tag,
    input  logic [7:0]              data_byte,
    input  logic                    last_byte,
    output tlvx_pkg::parse_state_t  nxt,
    output tlvx_pkg::parse_result_t res
);
    import tlvx_pkg::*;

    parse_state_t  st;
    parse_result_t r;
    logic [31:0]   merged;

    always_comb
    begin
        case (cur.byte_index)
            2'd0:    merged = cur.value_accum | {24'd0, data_byte};
            2'd1:    merged = cur.value_accum | {16'd0, data_byte, 8'd0};
            2'd2:    merged = cur.value_accum | {8'd0, data_byte, 16'd0};
            default: merged = cur.value_accum | {data_byte, 24'd0};
        endcase
    end

    always_comb
    begin
        st = cur;
        r  = '{emit: 1'b0, status: ST_FOUND, value: 32'd0};

        unique case (cur.phase)
            PH_SKIPLEN:
            begin
                if (data_byte == 8'd0)
                begin
                    st.phase = PH_TAG;
                end
                else
                begin
                    st.skip_count = data_byte;
                    st.phase      = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                st.skip_count = cur.skip_count - 8'd1;
                if (cur.skip_count == 8'd1)
                begin
                    st.phase = PH_TAG;
                end
            end
            PH_MATCHLEN:
            begin
                if (data_byte == LEN_ONE || data_byte == LEN_TWO || data_byte == LEN_FOUR)
                begin
                    st.value_len   = data_byte[2:0];
                    st.byte_index  = 2'd0;
                    st.value_accum = 32'd0;
                    st.phase       = PH_VALUE;
                end
                else
                begin
                    r.emit   = 1'b1;
                    r.status = ST_BADLEN;
                    st.phase = PH_DONE;
                end
            end
            PH_VALUE:
            begin
                st.value_accum = merged;
                if (({1'b0, cur.byte_index} + 3'd1) >= cur.value_len)
                begin
                    r.emit   = 1'b1;
                    r.status = ST_FOUND;
                    r.value  = merged;
                    st.phase = PH_DONE;
                end
                else
                begin
                    st.byte_index = cur.byte_index + 2'd1;
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
                // Unused codes behave like the tag phase.
                st.phase = (data_byte == target_tag) ? PH_MATCHLEN : PH_SKIPLEN;
            end
        endcase

        if (last_byte)
        begin
            if (!r.emit && st.phase != PH_DONE)
            begin
                r.emit   = 1'b1;
                r.status = (st.phase == PH_MATCHLEN || st.phase == PH_VALUE) ?
                           ST_TRUNC : ST_NOTFOUND;
                r.value  = 32'd0;
            end
            st = STATE_REARM;
        end
    end

    assign nxt = st;
    assign res = r;

endmodule

/* rtl/core/tlv_tag_integer_extractor_core.sv */
// A byte is taken into the input register and its result into the output register.
// Throughput: one byte per cycle, save for the stall below; the parser state
// register closes the only loop. A byte that yields a result waits in the input
// register while the output register holds an unaccepted result; other bytes
// pass on regardless. Reset (rst_n low, asynchronous) clears both valids, the
// parser state and the target tag register.
module tlv_tag_integer_extractor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] value
);
    import tlvx_pkg::*;

    logic          in_vld_reg;
    logic          in_vld_next;
    logic [7:0]    byte_reg;
    logic          last_reg;
    logic [7:0]    tag_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t step_res;
    logic          out_vld_reg;
    logic          out_vld_next;
    logic [1:0]    status_reg;
    logic [31:0]   value_reg;
    logic          advance;
    logic          accept;

    tlvx_step u_step (
        .cur        (state_reg),
        .target_tag (tag_reg),
        .data_byte  (byte_reg),
        .last_byte  (last_reg),
        .nxt        (state_next),
        .res        (step_res)
    );

    // The held item may move on unless it has a result and the output is blocked.
    assign advance  = !(step_res.emit && out_vld_reg && out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (in_vld_reg && advance && step_res.emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            tag_reg     <= 8'd0;
            state_reg   <= STATE_REARM;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_write_en)
            begin
                tag_reg <= cfg_write_data;
            end
            if (in_vld_reg && advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
        if (in_vld_reg && advance && step_res.emit)
        begin
            status_reg <= step_res.status;
            value_reg  <= step_res.value;
        end
    end

    assign out_valid = out_vld_reg;
    assign status    = status_reg;
    assign value     = value_reg;

endmodule

/* rtl/core/tlvx_checker.sv */
module tlvx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [31:0] value
);
    import tlvx_pkg::*;

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(value))
        else $error("result changed while stalled");

    // Only a found result carries a value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_FOUND |-> value == 32'd0)
        else $error("nonzero value on a result other than found");

    // The input side is only held up by a blocked output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output is free");

    // Once the output frees up, the input cannot stay stalled.
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_stall |-> 1'b0)
        else $error("input stalled with output not stalled");

endmodule

bind tlv_tag_integer_extractor_core tlvx_checker u_tlvx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .value     (value)
);
